@@ rtl/totp_hmac_sha1_code_generator_assert.svh @@
// Assertion macros for the TOTP generator checker.
`ifndef TOTP_HMAC_SHA1_CODE_GENERATOR_ASSERT_SVH
`define TOTP_HMAC_SHA1_CODE_GENERATOR_ASSERT_SVH

// Implication checked on every rising clock edge, off during reset.
`define TOTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("totp check failed");

// Next-cycle implication, off during reset.
`define TOTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("totp check failed");

`endif

@@ rtl/totp_pkg.sv @@
package totp_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] IPAD = 32'h36363636;
  localparam logic [31:0] OPAD = 32'h5C5C5C5C;
  localparam logic [31:0] PAD_ONE = 32'h80000000;
  localparam logic [31:0] LEN_INNER = 32'd576;
  localparam logic [31:0] LEN_OUTER = 32'd672;
  localparam logic [31:0] CODE_MOD = 32'd1000000;
  // floor((2^32 - 1) / 1e6): quotient estimate is at most 2 low
  localparam logic [31:0] CODE_RECIP = 32'hFFFF_FFFF / CODE_MOD;
  localparam int KEY_WORDS = 8;
  localparam logic [2:0] CFG_KEY_LAST = 3'd7;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_ROUND = 8'b0000_1000,
    ST_ADD   = 8'b0001_0000,
    ST_TRUNC = 8'b0010_0000,
    ST_MOD   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction
endpackage

@@ rtl/totp_hmac_sha1_code_generator.sv @@
// Channel | Ports                                   | Transaction
// in      | in_valid/in_ready, in_unix_seconds      | one timestamp
// out     | out_valid/out_ready, otp/left/fresh     | one result per timestamp
// cfg     | cfg_we, cfg_index, cfg_wdata            | key word write, no wait
// Sequence: a same step runs the divide, then the output load. A new step also adds 4
// SHA-1 blocks (load, 80 rounds, add), a byte-shift truncation and a second divide
// for mod 1e6. One round unit and one 32x32 multiplier (reciprocal divide) are
// shared.
// Reset: synchronous active-low, clears key, held step/code and control.
// Stalls: in_ready is high only in idle; a finished result waits in ST_OUT while
// the output register still holds an unaccepted transaction.
module totp_hmac_sha1_code_generator #(
  parameter int STEP_SECONDS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_otp_code,
  output logic [4:0]  out_seconds_left,
  output logic        out_fresh_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import totp_pkg::*;

  localparam logic [31:0] STEP_C = 32'(STEP_SECONDS);
  // floor((2^32 - 1) / step): quotient estimate is at most 2 low
  localparam logic [31:0] STEP_RECIP = 32'hFFFF_FFFF / STEP_C;

  state_t state_r;
  logic [63:0] key_r [KEY_WORDS];
  logic [31:0] held_step_r;
  logic        step_known_r;
  logic [19:0] held_code_r;
  logic [4:0]  left_r;
  logic        fresh_r;

  // output register
  logic [19:0] out_code_r;
  logic [4:0]  out_left_r;
  logic        out_fresh_r;
  logic        out_load;

  // reciprocal divider: q = dq * recip >> 32, rem = dq - q * div, then fix up
  logic [31:0] dq_r, q_r, rem_r, div_r, recip_r;
  logic [1:0]  dcnt_r;     // 0: estimate, 1: back-multiply, 2: correct
  logic        mod_pass_r; // 0: time/step, 1: bin % 1e6
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // SHA-1 engine
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] h_r [5];
  logic [31:0] ih_r [5];
  logic [6:0]  rnd_r;
  logic [1:0]  blk_r;   // 0 key^ipad, 1 step, 2 key^opad, 3 inner digest
  logic [4:0]  tcnt_r;

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid || out_ready);

  // one shared multiplier
  assign mul_a = (dcnt_r == 2'd0) ? dq_r : q_r;
  assign mul_b = (dcnt_r == 2'd0) ? recip_r : div_r;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // round logic
  logic [31:0] f, k, t, wnew;
  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = K3;
    end
    wnew = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 5'd1);
    t = rotl(a_r, 5'd5) + f + e_r + k + w_r[0];
  end

  // message for the block being loaded
  logic [31:0] blkw [16];
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blkw[i] = '0;
    end
    case (blk_r)
      2'd0, 2'd2: begin
        for (int i = 0; i < 16; i++) begin
          blkw[i] = (i % 2 == 1 ? key_r[i / 2][31:0] : key_r[i / 2][63:32])
                    ^ (blk_r == 2'd0 ? IPAD : OPAD);
        end
      end
      2'd1: begin
        blkw[1] = held_step_r;
        blkw[2] = PAD_ONE;
        blkw[15] = LEN_INNER;
      end
      default: begin
        for (int i = 0; i < 5; i++) begin
          blkw[i] = ih_r[i];
        end
        blkw[5] = PAD_ONE;
        blkw[15] = LEN_OUTER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < KEY_WORDS; i++) key_r[i] <= '0;
      held_step_r <= '0;
      step_known_r <= 1'b0;
      held_code_r <= '0;
      out_valid <= 1'b0;
      out_code_r <= '0;
      out_left_r <= '0;
      out_fresh_r <= 1'b0;
      dcnt_r <= '0;
      mod_pass_r <= 1'b0;
      rnd_r <= '0;
      blk_r <= '0;
      tcnt_r <= '0;
    end else begin
      if (cfg_we && cfg_index <= CFG_KEY_LAST) key_r[cfg_index] <= cfg_wdata;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            dq_r <= in_unix_seconds;
            div_r <= STEP_C;
            recip_r <= STEP_RECIP;
            dcnt_r <= '0;
            mod_pass_r <= 1'b0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          case (dcnt_r)
            2'd0: begin
              q_r <= mul_p[63:32];
              dcnt_r <= 2'd1;
            end
            2'd1: begin
              // estimate never exceeds the true quotient, so no underflow
              rem_r <= dq_r - mul_p[31:0];
              dcnt_r <= 2'd2;
            end
            default: begin
              if (rem_r >= div_r) begin
                rem_r <= rem_r - div_r;
                q_r <= q_r + 32'd1;
              end else if (mod_pass_r) begin
                held_code_r <= rem_r[19:0];
                fresh_r <= 1'b1;
                state_r <= ST_OUT;
              end else begin
                left_r <= 5'(STEP_C - rem_r);
                if (!step_known_r || q_r != held_step_r) begin
                  held_step_r <= q_r;
                  step_known_r <= 1'b1;
                  blk_r <= 2'd0;
                  h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
                  state_r <= ST_LOAD;
                end else begin
                  fresh_r <= 1'b0;
                  state_r <= ST_OUT;
                end
              end
            end
          endcase
        end
        ST_LOAD: begin
          for (int i = 0; i < 16; i++) w_r[i] <= blkw[i];
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          rnd_r <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= wnew;
          e_r <= d_r; d_r <= c_r; c_r <= rotl(b_r, 5'd30); b_r <= a_r; a_r <= t;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) state_r <= ST_ADD;
        end
        ST_ADD: begin
          blk_r <= blk_r + 2'd1;
          if (blk_r == 2'd1) begin
            ih_r[0] <= h_r[0] + a_r; ih_r[1] <= h_r[1] + b_r; ih_r[2] <= h_r[2] + c_r;
            ih_r[3] <= h_r[3] + d_r; ih_r[4] <= h_r[4] + e_r;
            h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
            state_r <= ST_LOAD;
          end else begin
            h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
            h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
            if (blk_r == 2'd3) begin
              tcnt_r <= {1'b0, (h_r[4][3:0] + e_r[3:0])};
              state_r <= ST_TRUNC;
            end else begin
              state_r <= ST_LOAD;
            end
          end
        end
        ST_TRUNC: begin
          // shift the digest left one byte a cycle until the offset byte leads
          if (tcnt_r == 5'd0) begin
            dq_r <= {1'b0, h_r[0][30:0]};
            div_r <= CODE_MOD;
            recip_r <= CODE_RECIP;
            dcnt_r <= '0;
            mod_pass_r <= 1'b1;
            state_r <= ST_DIV;
          end else begin
            h_r[0] <= {h_r[0][23:0], h_r[1][31:24]};
            h_r[1] <= {h_r[1][23:0], h_r[2][31:24]};
            h_r[2] <= {h_r[2][23:0], h_r[3][31:24]};
            h_r[3] <= {h_r[3][23:0], h_r[4][31:24]};
            h_r[4] <= {h_r[4][23:0], 8'h00};
            tcnt_r <= tcnt_r - 5'd1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_code_r <= held_code_r;
            out_left_r <= left_r;
            out_fresh_r <= fresh_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_otp_code = out_code_r;
  assign out_seconds_left = out_left_r;
  assign out_fresh_code = out_fresh_r;
endmodule

@@ rtl/totp_chk.sv @@
`include "totp_hmac_sha1_code_generator_assert.svh"
module totp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] out_otp_code,
  input logic [4:0]  out_seconds_left
);
  `TOTP_ASSERT_IMP(a_code_range, out_valid, out_otp_code < 20'd1000000)
  `TOTP_ASSERT_IMP(a_left_range, out_valid, out_seconds_left != 5'd0)
  `TOTP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `TOTP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind totp_hmac_sha1_code_generator totp_chk u_totp_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_otp_code(out_otp_code), .out_seconds_left(out_seconds_left)
);
